FILE: rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants of the byte stack unit
// Command and error codes, transaction structs and the cell control word.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int MAX_POP_DEF   = 9;
  localparam int OUT_CNT_W     = 5;
  localparam logic [7:0] UNDERFLOW_BYTE = 8'h20;

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_SEARCH  = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_REVERSE = 3'd5,
    CMD_POP_N   = 3'd6,
    CMD_QUERY   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_EMPTY    = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  // What every cell does at the next clock edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_WRITE,
    CELL_REV
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] key;
  } bsr_cell_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] item_value;
    logic [3:0] pop_count;
  } bsr_in_t;

  typedef struct packed {
    logic [7:0]           popped_value;
    logic                 popped_valid;
    logic                 found;
    logic [1:0]           error_code;
    logic [OUT_CNT_W-1:0] element_count;
    logic                 is_empty;
    logic [7:0]           top_byte;
    logic [7:0]           bottom_byte;
    logic                 last;
  } bsr_out_t;

  // Per-result fields that belong to the command rather than to the stack.
  typedef struct packed {
    logic [7:0] popped_value;
    logic       popped_valid;
    logic       found;
    logic [1:0] error_code;
    logic       last;
  } bsr_desc_t;

endpackage

FILE: rtl/bsr_cell.sv
// ----------------------------------------------------------------------------
// bsr_cell: one byte cell of the stack row
// Holds one byte, shifts with its neighbors on push and pop, takes its
// mirrored partner on reverse, and compares itself against the search key.
// ----------------------------------------------------------------------------
module bsr_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic                   clk,
  input  bsr_pkg::bsr_cell_ctl_t ctl,
  input  logic [7:0]             from_above,
  input  logic [7:0]             from_below,
  input  logic [7:0]             rev_src,
  input  logic                   in_use,
  output logic [7:0]             value,
  output logic                   match
);
  import bsr_pkg::*;

  logic [7:0] value_r;
  logic [7:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    case (ctl.op)
      CELL_PUSH:  value_nxt = from_above;
      CELL_POP:   value_nxt = from_below;
      CELL_WRITE: value_nxt = IS_HEAD ? from_above : value_r;
      CELL_REV:   value_nxt = in_use ? rev_src : value_r;
      default:    value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign match = in_use && (value_r == ctl.key);

endmodule

FILE: rtl/bsr_ctrl.sv
// ----------------------------------------------------------------------------
// bsr_ctrl: command decode, fill count and pop-many sequencing
// Turns each command into a cell operation, keeps the element count and
// registers the per-result fields, one result per cycle.
// ----------------------------------------------------------------------------
module bsr_ctrl #(
  parameter int DEPTH         = bsr_pkg::DEPTH_DEF,
  parameter int MAX_MULTI_POP = bsr_pkg::MAX_POP_DEF,
  localparam int CNT_W        = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bsr_pkg::bsr_in_t   in_data,
  input  logic [7:0]         head_byte,
  input  logic               found_any,
  output logic               busy,
  output bsr_pkg::cell_op_t  cell_op,
  output logic [CNT_W-1:0]   fill,
  output logic               out_valid,
  output bsr_pkg::bsr_desc_t desc
);
  import bsr_pkg::*;

  localparam int REM_W = $clog2(MAX_MULTI_POP + 1);
  localparam int CMP_W = (REM_W > 4) ? REM_W : 4;

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             valid_r, valid_nxt;
  bsr_desc_t        desc_r, desc_nxt;
  logic             accept;
  logic             empty;
  logic [CMP_W-1:0] req_cnt;

  assign accept = start && (rem_r == '0);
  assign empty  = (fill_r == '0);

  always_comb begin
    if (CMP_W'(in_data.pop_count) > CMP_W'(MAX_MULTI_POP)) begin
      req_cnt = CMP_W'(MAX_MULTI_POP);
    end else begin
      req_cnt = CMP_W'(in_data.pop_count);
    end
  end

  always_comb begin
    fill_nxt  = fill_r;
    rem_nxt   = rem_r;
    valid_nxt = 1'b0;
    cell_op   = CELL_HOLD;
    desc_nxt  = '{popped_value: 8'h00, popped_valid: 1'b0, found: 1'b0,
                  error_code: ERR_NONE, last: 1'b1};
    if (accept) begin
      valid_nxt = 1'b1;
      case (cmd_t'(in_data.cmd))
        CMD_PUSH: begin
          if (fill_r == CNT_W'(DEPTH)) begin
            desc_nxt.error_code = ERR_OVERFLOW;
          end else begin
            cell_op  = CELL_PUSH;
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
        CMD_POP, CMD_POP_N: begin
          if ((cmd_t'(in_data.cmd) == CMD_POP_N) && (in_data.pop_count == 4'd0)) begin
            cell_op = CELL_HOLD;
          end else begin
            desc_nxt.popped_valid = 1'b1;
            if (cmd_t'(in_data.cmd) == CMD_POP_N) begin
              rem_nxt       = REM_W'(req_cnt - CMP_W'(1));
              desc_nxt.last = (req_cnt == CMP_W'(1));
            end
            if (empty) begin
              desc_nxt.popped_value = UNDERFLOW_BYTE;
              desc_nxt.error_code   = ERR_EMPTY;
            end else begin
              desc_nxt.popped_value = head_byte;
              cell_op               = CELL_POP;
              fill_nxt              = fill_r - CNT_W'(1);
            end
          end
        end
        CMD_SEARCH: begin
          desc_nxt.found = found_any;
        end
        CMD_REPLACE: begin
          if (empty) begin
            desc_nxt.error_code = ERR_EMPTY;
          end else begin
            cell_op = CELL_WRITE;
          end
        end
        CMD_CLEAR: begin
          fill_nxt = '0;
        end
        CMD_REVERSE: begin
          cell_op = CELL_REV;
        end
        default: begin
          cell_op = CELL_HOLD;
        end
      endcase
    end else if (rem_r != '0) begin
      // Further pops of a pop-many command, one per cycle.
      valid_nxt             = 1'b1;
      rem_nxt               = rem_r - REM_W'(1);
      desc_nxt.popped_valid = 1'b1;
      desc_nxt.last         = (rem_r == REM_W'(1));
      if (empty) begin
        desc_nxt.popped_value = UNDERFLOW_BYTE;
        desc_nxt.error_code   = ERR_EMPTY;
      end else begin
        desc_nxt.popped_value = head_byte;
        cell_op               = CELL_POP;
        fill_nxt              = fill_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      rem_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      rem_r   <= rem_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
  end

  assign busy      = (rem_r != '0);
  assign fill      = fill_r;
  assign out_valid = valid_r;
  assign desc      = desc_r;

endmodule

FILE: rtl/byte_stack_with_search_and_reverse_unit.sv
// ----------------------------------------------------------------------------
// byte_stack_with_search_and_reverse_unit: bounded LIFO stack of bytes
// Register-cell stack with push, pop, pop-many, search, replace-top, clear,
// reverse and status query.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge where start is high and busy is low.
// Its result appears on out_data, marked by out_valid, in the cycle right
// after that edge and stays for exactly one cycle; the receiver cannot hold
// it, so it must capture every result when out_valid is high. Every command
// gives a single result, except pop-many, which produces one result per
// cycle, min(pop_count, MAX_MULTI_POP) of them, or one when pop_count is
// zero, and holds busy high after the first of them until the last pop has
// been done, as the stack row shifts by one position per cycle. A new
// command may be started in the same cycle that the final result of the
// previous one is shown. Each result carries the element count and the top
// and bottom bytes as they stand after the operation it reports. The stack
// resets empty, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_stack_with_search_and_reverse_unit #(
  parameter int DEPTH         = bsr_pkg::DEPTH_DEF,
  parameter int MAX_MULTI_POP = bsr_pkg::MAX_POP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bsr_pkg::bsr_in_t  in_data,
  output logic              out_valid,
  output bsr_pkg::bsr_out_t out_data
);
  import bsr_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // Cell 0 is the top of the stack; cell fill-1 holds the bottom byte.
  logic [7:0]       cell_val [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [CNT_W-1:0] fill;
  cell_op_t         cell_op;
  bsr_cell_ctl_t    cell_ctl;
  bsr_desc_t        desc;
  logic [CNT_W-1:0] bottom_pos;

  assign cell_ctl = '{op: cell_op, key: in_data.item_value};

  bsr_ctrl #(
    .DEPTH         (DEPTH),
    .MAX_MULTI_POP (MAX_MULTI_POP)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .head_byte (cell_val[0]),
    .found_any (|cell_match),
    .busy      (busy),
    .cell_op   (cell_op),
    .fill      (fill),
    .out_valid (out_valid),
    .desc      (desc)
  );

  // The row of cells. Push shifts toward higher cells, pop toward cell 0;
  // on reverse each occupied cell loads its mirror position in the
  // occupied range, so the old bottom byte becomes the new top byte.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CNT_W-1:0] rev_pos;
    logic [7:0]       above;
    logic [7:0]       below;
    logic             used;

    assign rev_pos = fill - CNT_W'(1) - CNT_W'(i);
    assign used    = (CNT_W'(i) < fill);

    if (i == 0) begin : g_head
      assign above = in_data.item_value;
    end else begin : g_body
      assign above = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign below = cell_val[i];
    end else begin : g_inner
      assign below = cell_val[i+1];
    end

    bsr_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .from_above (above),
      .from_below (below),
      .rev_src    (cell_val[rev_pos[IDX_W-1:0]]),
      .in_use     (used),
      .value      (cell_val[i]),
      .match      (cell_match[i])
    );
  end

  // Status fields come from the live stack, which during the cycle a result
  // is shown still holds the state left by the operation it reports.
  assign bottom_pos = fill - CNT_W'(1);

  always_comb begin
    out_data.popped_value  = desc.popped_value;
    out_data.popped_valid  = desc.popped_valid;
    out_data.found         = desc.found;
    out_data.error_code    = desc.error_code;
    out_data.last          = desc.last;
    out_data.element_count = OUT_CNT_W'(fill);
    out_data.is_empty      = (fill == '0);
    if (fill == '0) begin
      out_data.top_byte    = 8'h00;
      out_data.bottom_byte = 8'h00;
    end else begin
      out_data.top_byte    = cell_val[0];
      out_data.bottom_byte = cell_val[bottom_pos[IDX_W-1:0]];
    end
  end

endmodule
